### src/psp_pkg.sv
// Shared types and fixed widths for the point to segment proximity block.
// Used by psp_div_pipe, psp_sqrt_pipe and point_segment_proximity.
package psp_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 66;
    localparam int SUM_W   = 67;
    localparam int APER_W  = 31;
    localparam int REL_OUT_W = 17;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] begin_x;
        logic signed [COORD_W-1:0] begin_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_psp_in;

    typedef struct packed {
        logic                      hit;
        logic [REL_OUT_W-1:0]      rel;
        logic [APER_W-1:0]         distance;
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
    } t_psp_out;

    typedef enum logic [2:0] {
        REL_ZERO = 3'b001,
        REL_ONE  = 3'b010,
        REL_DIV  = 3'b100
    } t_rel_sel;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      miss;
        t_rel_sel                  sel;
    } t_psp_geo;

endpackage

### src/point_segment_proximity.sv
// Point to segment pick test, fully pipelined; one word accepted per cycle, busy stays low.
// Stages in order: 4 setup stages, the divider (COORD_FRAC_BITS + 1 stages), 4 projection
// stages, the square root (33) and the output.
// Throughput one word per cycle; the receiver cannot stall and each result strobes once.
// Synchronous active-low reset clears all valid bits and the aperture; words in flight drop.
// Depends on psp_pkg, psp_div_pipe and psp_sqrt_pipe.
module point_segment_proximity #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  psp_pkg::t_psp_in             i_item,
    output logic                         o_valid,
    output psp_pkg::t_psp_out            o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [psp_pkg::APER_W-1:0]   i_cfg_data
);

    localparam int FRAC   = COORD_FRAC_BITS;
    localparam int REL_W  = FRAC + 1;
    localparam int OX_W   = REL_W + 1 + psp_pkg::DIFF_W;
    localparam int GEO_W  = $bits(psp_pkg::t_psp_geo);
    localparam int SQS_W  = 1 + REL_W + 2 * psp_pkg::COORD_W;
    localparam int LAT    = 43 + FRAC;

    logic [psp_pkg::APER_W-1:0]     r_aperture;
    logic [2*psp_pkg::APER_W-1:0]   r_lim;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aperture <= '0;
        end else if (i_cfg_valid) begin
            r_aperture <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= r_aperture * r_aperture;
    end

    // stage A: capture word
    psp_pkg::t_psp_in r_a;
    logic             r_a_vld;

    // stage B: differences and box reject
    logic signed [psp_pkg::DIFF_W-1:0] w_dx, w_dy, w_ux, w_uy;
    logic signed [psp_pkg::COORD_W-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic signed [psp_pkg::COORD_W+1:0] w_ap;
    logic                               w_miss;

    always_comb begin
        w_dx   = 33'(r_a.end_x) - 33'(r_a.begin_x);
        w_dy   = 33'(r_a.end_y) - 33'(r_a.begin_y);
        w_ux   = 33'(r_a.point_x) - 33'(r_a.begin_x);
        w_uy   = 33'(r_a.point_y) - 33'(r_a.begin_y);
        w_lo_x = (r_a.begin_x < r_a.end_x) ? r_a.begin_x : r_a.end_x;
        w_hi_x = (r_a.begin_x > r_a.end_x) ? r_a.begin_x : r_a.end_x;
        w_lo_y = (r_a.begin_y < r_a.end_y) ? r_a.begin_y : r_a.end_y;
        w_hi_y = (r_a.begin_y > r_a.end_y) ? r_a.begin_y : r_a.end_y;
        w_ap   = $signed(34'(r_aperture));
        w_miss = (34'(r_a.point_x) < 34'(w_lo_x) - w_ap)
              || (34'(r_a.point_x) > 34'(w_hi_x) + w_ap)
              || (34'(r_a.point_y) < 34'(w_lo_y) - w_ap)
              || (34'(r_a.point_y) > 34'(w_hi_y) + w_ap);
    end

    logic signed [psp_pkg::DIFF_W-1:0]  r_b_dx, r_b_dy, r_b_ux, r_b_uy;
    logic signed [psp_pkg::COORD_W-1:0] r_b_bx, r_b_by, r_b_px, r_b_py;
    logic                               r_b_miss, r_b_vld;

    // stage C: products
    logic signed [psp_pkg::SQ_W-1:0]    r_c_dd, r_c_ee, r_c_ud, r_c_ve;
    logic signed [psp_pkg::DIFF_W-1:0]  r_c_dx, r_c_dy;
    logic signed [psp_pkg::COORD_W-1:0] r_c_bx, r_c_by, r_c_px, r_c_py;
    logic                               r_c_miss, r_c_vld;

    // stage D: sums
    logic signed [psp_pkg::SUM_W-1:0]   r_d_den, r_d_num;
    logic signed [psp_pkg::DIFF_W-1:0]  r_d_dx, r_d_dy;
    logic signed [psp_pkg::COORD_W-1:0] r_d_bx, r_d_by, r_d_px, r_d_py;
    logic                               r_d_miss, r_d_vld;

    always_ff @(posedge i_clk) begin
        r_a      <= i_item;
        r_b_dx   <= w_dx;
        r_b_dy   <= w_dy;
        r_b_ux   <= w_ux;
        r_b_uy   <= w_uy;
        r_b_bx   <= r_a.begin_x;
        r_b_by   <= r_a.begin_y;
        r_b_px   <= r_a.point_x;
        r_b_py   <= r_a.point_y;
        r_b_miss <= w_miss;
        r_c_dd   <= r_b_dx * r_b_dx;
        r_c_ee   <= r_b_dy * r_b_dy;
        r_c_ud   <= r_b_ux * r_b_dx;
        r_c_ve   <= r_b_uy * r_b_dy;
        r_c_dx   <= r_b_dx;
        r_c_dy   <= r_b_dy;
        r_c_bx   <= r_b_bx;
        r_c_by   <= r_b_by;
        r_c_px   <= r_b_px;
        r_c_py   <= r_b_py;
        r_c_miss <= r_b_miss;
        r_d_den  <= 67'(r_c_dd) + 67'(r_c_ee);
        r_d_num  <= 67'(r_c_ud) + 67'(r_c_ve);
        r_d_dx   <= r_c_dx;
        r_d_dy   <= r_c_dy;
        r_d_bx   <= r_c_bx;
        r_d_by   <= r_c_by;
        r_d_px   <= r_c_px;
        r_d_py   <= r_c_py;
        r_d_miss <= r_c_miss;
    end

    // classify projection parameter
    psp_pkg::t_psp_geo w_geo;

    always_comb begin
        w_geo.dx   = r_d_dx;
        w_geo.dy   = r_d_dy;
        w_geo.bx   = r_d_bx;
        w_geo.by   = r_d_by;
        w_geo.px   = r_d_px;
        w_geo.py   = r_d_py;
        w_geo.miss = r_d_miss;
        priority if (r_d_den == '0 || r_d_num <= 0) begin
            w_geo.sel = psp_pkg::REL_ZERO;
        end else if (r_d_num >= r_d_den) begin
            w_geo.sel = psp_pkg::REL_ONE;
        end else begin
            w_geo.sel = psp_pkg::REL_DIV;
        end
    end

    logic              w_div_vld;
    logic [FRAC:0]     w_quot;
    logic [GEO_W-1:0]  w_div_side;
    psp_pkg::t_psp_geo w_dg;
    logic [REL_W-1:0]  w_rel;

    psp_div_pipe #(
        .FRAC   (FRAC),
        .SIDE_W (GEO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld),
        .i_num   (unsigned'(r_d_num)),
        .i_den   (unsigned'(r_d_den)),
        .i_side  (w_geo),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    assign w_dg = psp_pkg::t_psp_geo'(w_div_side);

    always_comb begin
        unique case (w_dg.sel)
            psp_pkg::REL_ZERO: w_rel = '0;
            psp_pkg::REL_ONE:  w_rel = REL_W'(1) << FRAC;
            psp_pkg::REL_DIV:  w_rel = w_quot;
            default:           w_rel = '0;
        endcase
    end

    // stage F: offsets, G: nearest point, H: residual, I: squares
    logic signed [OX_W-1:0]             r_f_ox, r_f_oy;
    logic [REL_W-1:0]                   r_f_rel, r_g_rel, r_h_rel, r_i_rel;
    logic signed [psp_pkg::COORD_W-1:0] r_f_bx, r_f_by, r_f_px, r_f_py;
    logic                               r_f_miss, r_g_miss, r_h_miss, r_i_miss;
    logic                               r_f_vld, r_g_vld, r_h_vld, r_i_vld;
    logic signed [psp_pkg::COORD_W-1:0] r_g_qx, r_g_qy, r_g_px, r_g_py;
    logic signed [psp_pkg::COORD_W-1:0] r_h_qx, r_h_qy, r_i_qx, r_i_qy;
    logic signed [psp_pkg::DIFF_W-1:0]  r_h_rx, r_h_ry;
    logic [psp_pkg::SQ_W-1:0]           r_i_rr, r_i_ss;
    logic signed [OX_W-1:0]             w_oxf, w_oyf;

    assign w_oxf = r_f_ox >>> FRAC;
    assign w_oyf = r_f_oy >>> FRAC;

    always_ff @(posedge i_clk) begin
        r_f_ox   <= $signed({1'b0, w_rel}) * w_dg.dx;
        r_f_oy   <= $signed({1'b0, w_rel}) * w_dg.dy;
        r_f_rel  <= w_rel;
        r_f_bx   <= w_dg.bx;
        r_f_by   <= w_dg.by;
        r_f_px   <= w_dg.px;
        r_f_py   <= w_dg.py;
        r_f_miss <= w_dg.miss;
        r_g_qx   <= 32'(33'(r_f_bx) + 33'(w_oxf));
        r_g_qy   <= 32'(33'(r_f_by) + 33'(w_oyf));
        r_g_px   <= r_f_px;
        r_g_py   <= r_f_py;
        r_g_rel  <= r_f_rel;
        r_g_miss <= r_f_miss;
        r_h_rx   <= 33'(r_g_qx) - 33'(r_g_px);
        r_h_ry   <= 33'(r_g_qy) - 33'(r_g_py);
        r_h_qx   <= r_g_qx;
        r_h_qy   <= r_g_qy;
        r_h_rel  <= r_g_rel;
        r_h_miss <= r_g_miss;
        r_i_rr   <= r_h_rx * r_h_rx;
        r_i_ss   <= r_h_ry * r_h_ry;
        r_i_qx   <= r_h_qx;
        r_i_qy   <= r_h_qy;
        r_i_rel  <= r_h_rel;
        r_i_miss <= r_h_miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_f_vld <= w_div_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
        end
    end

    // squared distance against squared aperture
    logic [psp_pkg::SUM_W-1:0] w_d2;
    logic                      w_hit;
    logic                      w_sq_vld;
    logic [psp_pkg::ROOT_W-1:0] w_root;
    logic [SQS_W-1:0]          w_sq_side;
    logic                      w_s_hit;
    logic [REL_W-1:0]          w_s_rel;
    logic signed [psp_pkg::COORD_W-1:0] w_s_qx, w_s_qy;

    assign w_d2  = 67'(r_i_rr) + 67'(r_i_ss);
    assign w_hit = !r_i_miss && (w_d2 <= 67'(r_lim));

    psp_sqrt_pipe #(
        .SIDE_W (SQS_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_i_vld),
        .i_rad   (w_d2[psp_pkg::RAD_W-1:0]),
        .i_side  ({w_hit, r_i_rel, r_i_qx, r_i_qy}),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    assign {w_s_hit, w_s_rel, w_s_qx, w_s_qy} = w_sq_side;

    psp_pkg::t_psp_out r_out;
    logic              r_out_vld;

    always_ff @(posedge i_clk) begin
        if (w_s_hit) begin
            r_out.hit      <= 1'b1;
            r_out.rel      <= psp_pkg::REL_OUT_W'(w_s_rel);
            r_out.distance <= psp_pkg::APER_W'(w_root);
            r_out.proj_x   <= w_s_qx;
            r_out.proj_y   <= w_s_qy;
        end else begin
            r_out <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_sq_vld;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted word did not produce a result on time");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.hit |-> o_result.rel == '0 && o_result.distance == '0
            && o_result.proj_x == '0 && o_result.proj_y == '0)
        else $error("miss result carries nonzero fields");

    a_hit_in_aperture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.hit |-> o_result.distance <= r_aperture)
        else $error("hit distance exceeds aperture");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i_vld |-> $past(w_div_vld, 4))
        else $error("projection stage valid without divider output");

endmodule

### src/psp_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, num < den.
// Depends on psp_pkg for the operand width.
module psp_div_pipe #(
    parameter int FRAC   = 16,
    parameter int SIDE_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [psp_pkg::SUM_W-1:0]    i_num,
    input  logic [psp_pkg::SUM_W-1:0]    i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [FRAC:0]                o_quot,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int W = psp_pkg::SUM_W;

    logic [W-1:0]      r_rem  [FRAC+1];
    logic [W-1:0]      r_den  [FRAC+1];
    logic [FRAC:0]     r_quot [FRAC+1];
    logic [SIDE_W-1:0] r_side [FRAC+1];
    logic [FRAC:0]     r_vld;

    always_ff @(posedge i_clk) begin
        logic [W-1:0] sh;
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
        r_side[0] <= i_side;
        for (int k = 1; k <= FRAC; k++) begin
            sh = {r_rem[k-1][W-2:0], 1'b0};
            if (sh >= r_den[k-1]) begin
                r_rem[k]  <= sh - r_den[k-1];
                r_quot[k] <= {r_quot[k-1][FRAC-1:0], 1'b1};
            end else begin
                r_rem[k]  <= sh;
                r_quot[k] <= {r_quot[k-1][FRAC-1:0], 1'b0};
            end
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (FRAC+1)'({r_vld, i_valid});
        end
    end

    assign o_valid = r_vld[FRAC];
    assign o_quot  = r_quot[FRAC];
    assign o_side  = r_side[FRAC];

endmodule

### src/psp_sqrt_pipe.sv
// Pipelined floor integer square root of a 64-bit value, one result bit per stage.
// Depends on psp_pkg for widths.
module psp_sqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [psp_pkg::RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [psp_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int W = psp_pkg::RAD_W;
    localparam int N = psp_pkg::ROOT_W;

    logic [W-1:0]      r_x    [N+1];
    logic [W-1:0]      r_res  [N+1];
    logic [SIDE_W-1:0] r_side [N+1];
    logic [N:0]        r_vld;

    always_ff @(posedge i_clk) begin
        logic [W-1:0] bitv;
        logic [W-1:0] trial;
        r_x[0]    <= i_rad;
        r_res[0]  <= '0;
        r_side[0] <= i_side;
        for (int k = 1; k <= N; k++) begin
            bitv  = W'(1) << (W - 2 - 2 * (k - 1));
            trial = r_res[k-1] + bitv;
            if (r_x[k-1] >= trial) begin
                r_x[k]   <= r_x[k-1] - trial;
                r_res[k] <= (r_res[k-1] >> 1) + bitv;
            end else begin
                r_x[k]   <= r_x[k-1];
                r_res[k] <= r_res[k-1] >> 1;
            end
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (N+1)'({r_vld, i_valid});
        end
    end

    assign o_valid = r_vld[N];
    assign o_root  = N'(r_res[N]);
    assign o_side  = r_side[N];

endmodule

### test/point_segment_proximity_tb.sv
// Self-checking testbench for point_segment_proximity: directed and random segment picks.
// Expected results come from an in-bench integer model; depends on psp_pkg and the block.
module point_segment_proximity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    int err_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    function automatic longint floor_shift(input longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic psp_pkg::t_psp_out pick_test(input psp_pkg::t_psp_in w,
                                                    input logic [30:0] aper);
        psp_pkg::t_psp_out o;
        longint bx, by, ex, ey, px, py, ap, dx, dy, qx, qy, rx, ry;
        logic signed [127:0] num, den, d2, lim;
        longint unsigned rel;
        o = '0;
        bx = w.begin_x; by = w.begin_y; ex = w.end_x; ey = w.end_y;
        px = w.point_x; py = w.point_y; ap = aper;
        if (px < ((bx < ex ? bx : ex) - ap) || px > ((bx > ex ? bx : ex) + ap) ||
            py < ((by < ey ? by : ey) - ap) || py > ((by > ey ? by : ey) + ap))
            return o;
        dx = ex - bx;
        dy = ey - by;
        den = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        rel = 0;
        if (den != 0) begin
            num = 128'(px - bx) * 128'(dx) + 128'(py - by) * 128'(dy);
            if (num <= 0) rel = 0;
            else if (num >= den) rel = 64'd1 << FRAC;
            else rel = 64'((num <<< FRAC) / den);
        end
        qx = bx + floor_shift(longint'(rel) * dx);
        qy = by + floor_shift(longint'(rel) * dy);
        rx = qx - px;
        ry = qy - py;
        d2 = 128'(rx) * 128'(rx) + 128'(ry) * 128'(ry);
        lim = 128'(ap) * 128'(ap);
        if (lim < d2) return o;
        o.hit = 1'b1;
        o.rel = rel[16:0];
        o.distance = 31'(floor_root(d2[63:0]));
        o.proj_x = qx[31:0];
        o.proj_y = qy[31:0];
        return o;
    endfunction

    class pick_scoreboard;
        psp_pkg::t_psp_out pending[$];
        logic [30:0] aperture = '0;

        function void note_word(psp_pkg::t_psp_in w);
            pending.push_back(pick_test(w, aperture));
        endfunction

        task check_result(psp_pkg::t_psp_out got);
            psp_pkg::t_psp_out exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit !== exp_r.hit) report_mismatch($sformatf("hit %0b want %0b", got.hit, exp_r.hit));
            if (got.rel !== exp_r.rel) report_mismatch($sformatf("rel %0d want %0d", got.rel, exp_r.rel));
            if (got.distance !== exp_r.distance)
                report_mismatch($sformatf("distance %0d want %0d", got.distance, exp_r.distance));
            if (got.proj_x !== exp_r.proj_x)
                report_mismatch($sformatf("proj_x %0h want %0h", got.proj_x, exp_r.proj_x));
            if (got.proj_y !== exp_r.proj_y)
                report_mismatch($sformatf("proj_y %0h want %0h", got.proj_y, exp_r.proj_y));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    psp_pkg::t_psp_in i_item = '0;
    logic o_valid;
    psp_pkg::t_psp_out o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [psp_pkg::APER_W-1:0] i_cfg_data = '0;

    pick_scoreboard sb = new();
    int idle_cycles = 0;
    bit calm = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    point_segment_proximity i_dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_result);
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[point_segment_proximity] ERROR");
                $finish;
            end
        end
    end

    // start stays high after a word; idle and drain drop it
    task automatic send_word(input psp_pkg::t_psp_in w);
        while (!calm && $urandom_range(99) < 13) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_aperture(input logic [30:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.aperture = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] coord_near(input logic [31:0] c, input int span);
        return c + $signed($urandom_range(2 * span) - span);
    endfunction

    function automatic psp_pkg::t_psp_in near_pick(input int span);
        psp_pkg::t_psp_in w;
        w.begin_x = $urandom;
        w.begin_y = $urandom;
        case ($urandom_range(3))
            0: begin
                w.end_x = w.begin_x;
                w.end_y = w.begin_y;
            end
            1: begin
                w.end_x = $urandom;
                w.end_y = $urandom;
            end
            default: begin
                w.end_x = coord_near(w.begin_x, span * 4);
                w.end_y = coord_near(w.begin_y, span * 4);
            end
        endcase
        if ($urandom_range(1)) begin
            w.point_x = coord_near(w.begin_x, span);
            w.point_y = coord_near(w.begin_y, span);
        end else begin
            w.point_x = coord_near(w.end_x, span);
            w.point_y = coord_near(w.end_y, span);
        end
        return w;
    endfunction

    function automatic psp_pkg::t_psp_in make_word(input int bx, by, ex, ey, px, py);
        psp_pkg::t_psp_in w;
        w.begin_x = bx; w.begin_y = by; w.end_x = ex;
        w.end_y = ey; w.point_x = px; w.point_y = py;
        return w;
    endfunction

    logic [30:0] aper_set[6] = '{31'h0, 31'h7FFF_FFFF, 31'h0001_0000, 31'h0000_0400,
                                 31'h0100_0000, 31'h0000_0001};
    localparam int MINV = 32'sh8000_0000;
    localparam int MAXV = 32'sh7FFF_FFFF;

    initial begin
        psp_pkg::t_psp_in w;
        int n;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(make_word(0, 0, 65536, 0, 0, 0));
        write_aperture(31'h0001_0000);
        send_word(make_word(0, 0, 65536 * 4, 0, 65536 * 2, 65536));
        send_word(make_word(0, 0, 65536 * 4, 0, 65536 * 2, 65537));
        send_word(make_word(0, 0, 65536 * 4, 0, -65536, 0));
        send_word(make_word(0, 0, 65536 * 4, 0, -65537, 0));
        send_word(make_word(100, 100, 100, 100, 100, 65636));
        send_word(make_word(0, 0, 65536 * 4, 0, 65536 * 5, 0));
        send_word(make_word(0, 0, 3, 7, 1, 2));
        send_word(make_word(0, 0, -3, -7, -1, -3));
        write_aperture(31'h7FFF_FFFF);
        send_word(make_word(MINV, MINV, MAXV, MAXV, MAXV, MINV));
        send_word(make_word(MAXV, MINV, MINV, MAXV, MINV, MINV));
        send_word(make_word(MINV, MINV, MINV, MINV, MAXV, MAXV));
        send_word(make_word(MAXV, MAXV, MAXV, MAXV, MINV, MINV));
        send_word(make_word(MINV, 0, MAXV, 0, 0, MAXV));
        send_word(make_word(-1, -1, 1, 1, 0, 0));
        send_word(make_word(MAXV, 0, MINV, 1, 0, MINV));
        write_aperture(31'h0);
        send_word(make_word(5, 5, 5, 5, 5, 5));
        send_word(make_word(0, 0, 10, 10, 5, 5));
        send_word(make_word(0, 0, 10, 10, 5, 6));

        for (int phase = 0; phase < 6; phase++) begin
            write_aperture(phase == 5 ? 31'($urandom) : aper_set[phase]);
            calm = (phase == 2);
            for (n = 0; n < 340; n++) begin
                if ($urandom_range(99) < 85)
                    w = near_pick(phase == 1 ? 32'h7FFF_FFFF : 32'h0002_0000);
                else
                    w = psp_pkg::t_psp_in'({$urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom});
                send_word(w);
                if (n == 170 && phase == 3) drain();
            end
        end
        calm = 0;
        drain();
        if (err_count == 0) $display("[point_segment_proximity] OK");
        else $display("[point_segment_proximity] ERROR");
        $finish;
    end
endmodule

### files.f
src/psp_pkg.sv
src/psp_div_pipe.sv
src/psp_sqrt_pipe.sv
src/point_segment_proximity.sv
test/point_segment_proximity_tb.sv
